### hw/rtl/crpe_pkg.sv
// Shared types and constants for the Catmull-Rom point evaluator.
`timescale 1ns / 1ps
`default_nettype none

package crpe_pkg;

    // Store size and fixed-point format.
    localparam int MAX_POINTS = 256;
    localparam int FRAC_BITS  = 16;

    // Derived widths.
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SEG_W   = 8;
    localparam int SEL_W   = (CNT_W > SEG_W) ? CNT_W : SEG_W;
    localparam int T_W     = FRAC_BITS + 1;
    localparam int COORD_W = 32;
    // Horner accumulator width: covers |h| below 24 * 2^31.
    localparam int H_W     = COORD_W + 8;
    localparam int PR_W    = H_W + T_W + 1;

    localparam int ONE_VAL  = 1 << FRAC_BITS;
    localparam int HALF_VAL = 1 << (FRAC_BITS - 1);

    // Register stages inside the Horner datapath.
    localparam int HLAT = 8;

    typedef enum logic [1:0] {
        FUNC_CLEAR       = 2'd0,
        FUNC_APPEND      = 2'd1,
        FUNC_EVAL_SEG    = 2'd2,
        FUNC_EVAL_GLOBAL = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    // Per-transaction control that rides alongside the datapath.
    typedef struct packed {
        logic    zero;
        t_status status;
    } t_meta;

endpackage

`default_nettype wire

### hw/rtl/crpe_index.sv
// Segment selection, parameter mapping and neighbor address generation.
`timescale 1ns / 1ps
`default_nettype none

module crpe_index (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_vld,
    input  wire crpe_pkg::t_func                    i_func,
    input  wire logic [crpe_pkg::SEG_W-1:0]         i_seg,
    input  wire logic [crpe_pkg::T_W-1:0]           i_t,
    input  wire logic [crpe_pkg::CNT_W-1:0]         i_cnt,
    output logic                                    o_vld,
    output crpe_pkg::t_meta                         o_meta,
    output logic [crpe_pkg::T_W-1:0]                o_t,
    output logic [3:0][crpe_pkg::ADDR_W-1:0]        o_raddr
);

    localparam int F  = crpe_pkg::FRAC_BITS;
    localparam int AW = crpe_pkg::ADDR_W;
    localparam int CW = crpe_pkg::CNT_W;
    localparam int SW = crpe_pkg::SEL_W;
    localparam int TW = crpe_pkg::T_W;
    localparam logic [TW-1:0] ONE_T = TW'(crpe_pkg::ONE_VAL);

    logic [TW-1:0]   tc;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   last_seg;
    logic [F+AW-1:0] scaled;
    logic [SW-1:0]   gseg;
    logic [SW-1:0]   last_sel;
    logic [SW-1:0]   seg_sel;

    logic [AW-1:0]   n_seg;
    logic [AW-1:0]   n_last;
    logic [TW-1:0]   n_t;
    crpe_pkg::t_meta n_meta;

    logic [AW-1:0]   r_seg;
    logic [AW-1:0]   r_last;
    logic [TW-1:0]   r_t;
    crpe_pkg::t_meta r_meta;
    logic            r_vld;

    logic [CW-1:0]   seg_c;
    logic [CW-1:0]   last_c;
    logic [CW-1:0]   s1;
    logic [CW-1:0]   s2;

    assign tc       = (i_t > ONE_T) ? ONE_T : i_t;
    assign cnt_m1   = i_cnt - CW'(1);
    assign last_seg = i_cnt - CW'(2);
    assign scaled   = (F + AW)'(tc[F-1:0]) * (F + AW)'(cnt_m1[AW-1:0]);
    assign gseg     = SW'(scaled[F+AW-1:F]);
    assign last_sel = SW'(last_seg);
    assign seg_sel  = SW'(i_seg);

    always_comb begin
        n_seg         = '0;
        n_last        = '0;
        n_t           = '0;
        n_meta.zero   = 1'b1;
        n_meta.status = crpe_pkg::ST_OK;
        if (!(i_func == crpe_pkg::FUNC_EVAL_SEG || i_func == crpe_pkg::FUNC_EVAL_GLOBAL)
            || i_cnt == '0) begin
            if (i_func == crpe_pkg::FUNC_APPEND && i_cnt == CW'(crpe_pkg::MAX_POINTS)) begin
                n_meta.status = crpe_pkg::ST_FULL;
            end
        end else if (i_cnt == CW'(1)) begin
            // A single point: every neighbor is entry zero and t is zero.
            n_meta.zero = 1'b0;
        end else begin
            n_meta.zero = 1'b0;
            n_last      = cnt_m1[AW-1:0];
            case (i_func)
                crpe_pkg::FUNC_EVAL_SEG: begin
                    n_seg = (seg_sel > last_sel) ? AW'(last_sel) : AW'(seg_sel);
                    n_t   = tc;
                end
                default: begin
                    if (tc == ONE_T) begin
                        n_seg = AW'(last_sel);
                        n_t   = ONE_T;
                    end else begin
                        n_seg = (gseg > last_sel) ? AW'(last_sel) : AW'(gseg);
                        n_t   = TW'(scaled[F-1:0]);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_seg  <= n_seg;
        r_last <= n_last;
        r_t    <= n_t;
        r_meta <= n_meta;
    end

    // Neighbor indices, clamped to the first and last stored points.
    assign seg_c  = CW'(r_seg);
    assign last_c = CW'(r_last);
    assign s1     = seg_c + CW'(1);
    assign s2     = seg_c + CW'(2);

    assign o_raddr[0] = (r_seg == '0) ? '0 : r_seg - AW'(1);
    assign o_raddr[1] = r_seg;
    assign o_raddr[2] = (s1 > last_c) ? r_last : s1[AW-1:0];
    assign o_raddr[3] = (s2 > last_c) ? r_last : s2[AW-1:0];

    assign o_vld  = r_vld;
    assign o_meta = r_meta;
    assign o_t    = r_t;

endmodule

`default_nettype wire

### hw/rtl/crpe_store.sv
// Control point store: two copies, each with two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module crpe_store (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [crpe_pkg::ADDR_W-1:0]        i_waddr,
    input  wire crpe_pkg::t_point                   i_wdata,
    input  wire logic [3:0][crpe_pkg::ADDR_W-1:0]   i_raddr,
    output crpe_pkg::t_point [3:0]                  o_rd
);

    crpe_pkg::t_point       r_mem_a [crpe_pkg::MAX_POINTS];
    crpe_pkg::t_point       r_mem_b [crpe_pkg::MAX_POINTS];
    crpe_pkg::t_point [3:0] r_rd;

    // Copy A serves the two leading neighbors, copy B the two trailing ones.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_waddr] <= i_wdata;
            r_mem_b[i_waddr] <= i_wdata;
        end
        r_rd[0] <= r_mem_a[i_raddr[0]];
        r_rd[1] <= r_mem_a[i_raddr[1]];
        r_rd[2] <= r_mem_b[i_raddr[2]];
        r_rd[3] <= r_mem_b[i_raddr[3]];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

### hw/rtl/crpe_horner.sv
// One axis: Catmull-Rom coefficients and a pipelined Horner evaluation.
`timescale 1ns / 1ps
`default_nettype none

module crpe_horner (
    input  wire logic                                i_clk,
    input  wire logic signed [crpe_pkg::COORD_W-1:0] i_p0,
    input  wire logic signed [crpe_pkg::COORD_W-1:0] i_p1,
    input  wire logic signed [crpe_pkg::COORD_W-1:0] i_p2,
    input  wire logic signed [crpe_pkg::COORD_W-1:0] i_p3,
    input  wire logic [crpe_pkg::T_W-1:0]            i_t,
    output logic signed [crpe_pkg::COORD_W-1:0]      o_res,
    output logic                                     o_sat
);

    localparam int HW = crpe_pkg::H_W;
    localparam int PW = crpe_pkg::PR_W;
    localparam int TW = crpe_pkg::T_W;
    localparam int CW = crpe_pkg::COORD_W;
    localparam logic signed [PW-1:0] HALF_P = PW'(crpe_pkg::HALF_VAL);

    logic signed [HW-1:0] p0e, p1e, p2e, p3e;
    logic signed [HW-1:0] n_h3_half;
    logic                 n_ovf;

    // Stage 1: coefficients.
    logic signed [HW-1:0] r_a1, r_b1, r_c1, r_d1;
    logic [TW-1:0]        r_t1;
    // Stage 2: d * t.
    logic signed [PW-1:0] r_prod1;
    logic signed [HW-1:0] r_a2, r_b2, r_c2;
    logic [TW-1:0]        r_t2;
    // Stage 3: h1.
    logic signed [HW-1:0] r_h1, r_a3, r_b3;
    logic [TW-1:0]        r_t3;
    // Stage 4: h1 * t.
    logic signed [PW-1:0] r_prod2;
    logic signed [HW-1:0] r_a4, r_b4;
    logic [TW-1:0]        r_t4;
    // Stage 5: h2.
    logic signed [HW-1:0] r_h2, r_a5;
    logic [TW-1:0]        r_t5;
    // Stage 6: h2 * t.
    logic signed [PW-1:0] r_prod3;
    logic signed [HW-1:0] r_a6;
    // Stage 7: h3.
    logic signed [HW-1:0] r_h3;
    // Stage 8: halved and saturated result.
    logic signed [CW-1:0] r_res;
    logic                 r_sat;

    assign p0e = HW'(i_p0);
    assign p1e = HW'(i_p1);
    assign p2e = HW'(i_p2);
    assign p3e = HW'(i_p3);

    assign n_h3_half = (r_h3 + HW'(1)) >>> 1;
    assign n_ovf     = !((&n_h3_half[HW-1:CW-1]) || !(|n_h3_half[HW-1:CW-1]));

    always_ff @(posedge i_clk) begin
        r_a1 <= p1e <<< 1;
        r_b1 <= p2e - p0e;
        r_c1 <= (p0e <<< 1) - ((p1e <<< 2) + p1e) + (p2e <<< 2) - p3e;
        r_d1 <= ((p1e <<< 1) + p1e) - ((p2e <<< 1) + p2e) + p3e - p0e;
        r_t1 <= i_t;

        r_prod1 <= PW'(r_d1) * PW'($signed({1'b0, r_t1}));
        r_a2    <= r_a1;
        r_b2    <= r_b1;
        r_c2    <= r_c1;
        r_t2    <= r_t1;

        r_h1 <= r_c2 + HW'((r_prod1 + HALF_P) >>> crpe_pkg::FRAC_BITS);
        r_a3 <= r_a2;
        r_b3 <= r_b2;
        r_t3 <= r_t2;

        r_prod2 <= PW'(r_h1) * PW'($signed({1'b0, r_t3}));
        r_a4    <= r_a3;
        r_b4    <= r_b3;
        r_t4    <= r_t3;

        r_h2 <= r_b4 + HW'((r_prod2 + HALF_P) >>> crpe_pkg::FRAC_BITS);
        r_a5 <= r_a4;
        r_t5 <= r_t4;

        r_prod3 <= PW'(r_h2) * PW'($signed({1'b0, r_t5}));
        r_a6    <= r_a5;

        r_h3 <= r_a6 + HW'((r_prod3 + HALF_P) >>> crpe_pkg::FRAC_BITS);

        if (n_ovf) begin
            r_res <= n_h3_half[HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            r_res <= n_h3_half[CW-1:0];
        end
        r_sat <= n_ovf;
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

### hw/rtl/catmull_rom_point_eval.sv
// Top level of the uniform Catmull-Rom point evaluator.
`timescale 1ns / 1ps
`default_nettype none

// A fully pipelined evaluator over a store of up to 256 control points. A
// transaction is taken at every rising edge where start is high; busy never
// rises, so one transaction per clock is sustained indefinitely. Every
// transaction, whether it clears the store, appends a point or evaluates the
// curve, produces exactly one result, presented on the o_ result ports for a
// single cycle with o_strobe high. Results leave in the order their
// transactions arrived. The receiver cannot hold results off, so it must
// capture every strobed cycle. The pipeline runs through the registered
// accepted transaction, the index mapping stage (which carries the global
// parameter multiply), the registered read of the point store, the
// coefficient stage, the three sequential multiply and round steps of
// Horner's rule, each split into a multiply stage and an add stage, and a
// final halving and saturation stage. Appends are written into the store on
// the accepting edge, so an evaluation issued in the very next cycle already
// sees the new point. The store is held in two identical copies so all four
// neighbor points are read in the same cycle. Clear only resets the point
// count; stale entries beyond the count never reach an evaluation's result.

module catmull_rom_point_eval (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic [1:0]                          i_func,
    input  wire logic signed [crpe_pkg::COORD_W-1:0] i_coord_x,
    input  wire logic signed [crpe_pkg::COORD_W-1:0] i_coord_y,
    input  wire logic signed [crpe_pkg::COORD_W-1:0] i_coord_z,
    input  wire logic [crpe_pkg::SEG_W-1:0]          i_segment_index,
    input  wire logic [crpe_pkg::T_W-1:0]            i_param_t,
    output logic                                     busy,
    output logic                                     o_strobe,
    output logic signed [crpe_pkg::COORD_W-1:0]      o_out_x,
    output logic signed [crpe_pkg::COORD_W-1:0]      o_out_y,
    output logic signed [crpe_pkg::COORD_W-1:0]      o_out_z,
    output logic [1:0]                               o_status
);

    localparam int CW = crpe_pkg::CNT_W;
    localparam int HL = crpe_pkg::HLAT;

    crpe_pkg::t_func  in_func;
    logic             accept;
    logic             wr_en;
    crpe_pkg::t_point wr_pt;

    // Point count, updated on the accepting edge.
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;

    // Stage A: the accepted transaction.
    logic                            r_a_vld;
    crpe_pkg::t_func                 r_a_func;
    logic [crpe_pkg::SEG_W-1:0]      r_a_seg;
    logic [crpe_pkg::T_W-1:0]        r_a_t;
    logic [CW-1:0]                   r_a_cnt;

    // Stage B outputs from the index unit.
    logic                            b_vld;
    crpe_pkg::t_meta                 b_meta;
    logic [crpe_pkg::T_W-1:0]        b_t;
    logic [3:0][crpe_pkg::ADDR_W-1:0] b_raddr;

    // Stage C: aligned with the store read data.
    logic                            r_c_vld;
    crpe_pkg::t_meta                 r_c_meta;
    logic [crpe_pkg::T_W-1:0]        r_c_t;
    crpe_pkg::t_point [3:0]          c_pts;

    // Control that travels beside the Horner datapath.
    logic                            r_h_vld  [HL];
    crpe_pkg::t_meta                 r_h_meta [HL];

    logic signed [crpe_pkg::COORD_W-1:0] res_x, res_y, res_z;
    logic                                sat_x, sat_y, sat_z;

    // Output register.
    logic                                r_o_vld;
    logic signed [crpe_pkg::COORD_W-1:0] r_o_x, r_o_y, r_o_z;
    crpe_pkg::t_status                   r_o_status;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign in_func = crpe_pkg::t_func'(i_func);

    assign wr_en   = accept && in_func == crpe_pkg::FUNC_APPEND
                     && r_cnt != CW'(crpe_pkg::MAX_POINTS);
    assign wr_pt.x = i_coord_x;
    assign wr_pt.y = i_coord_y;
    assign wr_pt.z = i_coord_z;

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            case (in_func)
                crpe_pkg::FUNC_CLEAR:  n_cnt = '0;
                crpe_pkg::FUNC_APPEND: begin
                    if (wr_en) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                default: n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_a_vld <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_a_vld <= accept;
        end
        // The count seen by a transaction is the one before its own update.
        r_a_func <= in_func;
        r_a_seg  <= i_segment_index;
        r_a_t    <= i_param_t;
        r_a_cnt  <= r_cnt;
    end

    crpe_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_a_vld),
        .i_func  (r_a_func),
        .i_seg   (r_a_seg),
        .i_t     (r_a_t),
        .i_cnt   (r_a_cnt),
        .o_vld   (b_vld),
        .o_meta  (b_meta),
        .o_t     (b_t),
        .o_raddr (b_raddr)
    );

    crpe_store u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cnt[crpe_pkg::ADDR_W-1:0]),
        .i_wdata (wr_pt),
        .i_raddr (b_raddr),
        .o_rd    (c_pts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= b_vld;
        end
        r_c_meta <= b_meta;
        r_c_t    <= b_t;
    end

    crpe_horner u_horner_x (
        .i_clk (i_clk),
        .i_p0  (c_pts[0].x),
        .i_p1  (c_pts[1].x),
        .i_p2  (c_pts[2].x),
        .i_p3  (c_pts[3].x),
        .i_t   (r_c_t),
        .o_res (res_x),
        .o_sat (sat_x)
    );

    crpe_horner u_horner_y (
        .i_clk (i_clk),
        .i_p0  (c_pts[0].y),
        .i_p1  (c_pts[1].y),
        .i_p2  (c_pts[2].y),
        .i_p3  (c_pts[3].y),
        .i_t   (r_c_t),
        .o_res (res_y),
        .o_sat (sat_y)
    );

    crpe_horner u_horner_z (
        .i_clk (i_clk),
        .i_p0  (c_pts[0].z),
        .i_p1  (c_pts[1].z),
        .i_p2  (c_pts[2].z),
        .i_p3  (c_pts[3].z),
        .i_t   (r_c_t),
        .o_res (res_z),
        .o_sat (sat_z)
    );

    // Valid and control delay line matched to the Horner latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HL; i++) begin
                r_h_vld[i] <= 1'b0;
            end
        end else begin
            r_h_vld[0] <= r_c_vld;
            for (int i = 1; i < HL; i++) begin
                r_h_vld[i] <= r_h_vld[i-1];
            end
        end
        r_h_meta[0] <= r_c_meta;
        for (int i = 1; i < HL; i++) begin
            r_h_meta[i] <= r_h_meta[i-1];
        end
    end

    // Clear, append and an empty store force a zero point and keep their own
    // status; otherwise any saturated axis flags the whole result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_h_vld[HL-1];
        end
        if (r_h_meta[HL-1].zero) begin
            r_o_x      <= '0;
            r_o_y      <= '0;
            r_o_z      <= '0;
            r_o_status <= r_h_meta[HL-1].status;
        end else begin
            r_o_x      <= res_x;
            r_o_y      <= res_y;
            r_o_z      <= res_z;
            r_o_status <= (sat_x || sat_y || sat_z) ? crpe_pkg::ST_SAT : crpe_pkg::ST_OK;
        end
    end

    assign o_strobe = r_o_vld;
    assign o_out_x  = r_o_x;
    assign o_out_y  = r_o_y;
    assign o_out_z  = r_o_z;
    assign o_status = r_o_status;

endmodule

`default_nettype wire
